FILE: hw/rtl/stt_pkg.sv
package stt_pkg;

  // field widths of one table entry
  localparam int unsigned IdW     = 8;
  localparam int unsigned PeriodW = 24;
  localparam int unsigned RemainW = 26;
  localparam int unsigned DeltaW  = 16;

  // result status codes
  localparam logic [1:0] StRegistered = 2'd0;
  localparam logic [1:0] StFull       = 2'd1;
  localparam logic [1:0] StFired      = 2'd2;
  localparam logic [1:0] StNone       = 2'd3;

  // input mode codes
  localparam logic ModeTick     = 1'b0;
  localparam logic ModeRegister = 1'b1;

  // one stored timer
  typedef struct packed {
    logic [IdW-1:0]            id;
    logic                      periodic;
    logic [PeriodW-1:0]        period;
    logic signed [RemainW-1:0] remain;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic reg_commit;
    logic advance;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_valid;
    logic in_mode;
    logic empty;
    logic fire_blocked;
    logic last_entry;
    logic out_free;
  } sts_t;

endpackage

FILE: hw/rtl/stt_ram.sv
module stt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // single write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/stt_ctrl.sv
module stt_ctrl
  import stt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic in_ready_o
);

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StReg  = 4'b0010,
    StEval = 4'b0100,
    StFin  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (sts_i.in_valid) begin
          cmd_o.accept = 1'b1;
          if (sts_i.in_mode == ModeRegister) begin
            state_d = StReg;
          end else if (sts_i.empty) begin
            state_d = StFin;
          end else begin
            state_d = StEval;
          end
        end
      end
      StReg: begin
        if (sts_i.out_free) begin
          cmd_o.reg_commit = 1'b1;
          state_d          = StIdle;
        end
      end
      StEval: begin
        if (!sts_i.fire_blocked) begin
          cmd_o.advance = 1'b1;
          if (sts_i.last_entry) begin
            state_d = StFin;
          end
        end
      end
      StFin: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hw/rtl/stt_datapath.sv
module stt_datapath
  import stt_pkg::*;
#(
  parameter int unsigned MaxTimers = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request side
  input  logic        in_valid_i,
  input  logic [55:0] in_data_i,
  input  logic        in_mode_i,
  // result side
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [23:0] out_data_o,
  output logic [1:0]  out_status_o,
  output logic        out_last_o,
  // controller link
  input  cmd_t        cmd_i,
  output sts_t        sts_o
);

  localparam int unsigned IdxW = (MaxTimers > 1) ? $clog2(MaxTimers) : 1;
  localparam int unsigned CntW = $clog2(MaxTimers + 1);

  // latched request fields
  logic [DeltaW-1:0]  delta_q;
  logic [IdW-1:0]     id_q;
  logic               periodic_q;
  logic [PeriodW-1:0] period_q;

  // walk state
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] rd_q, rd_d;
  logic [CntW-1:0] wr_q, wr_d;
  logic            pend_valid_q, pend_valid_d;
  logic [IdW-1:0]  pend_id_q, pend_id_d;

  // output register
  logic              out_valid_q;
  logic [IdW-1:0]    out_id_q;
  logic [DeltaW-1:0] out_delta_q;
  logic [1:0]        out_status_q;
  logic              out_last_q;

  // ram signals
  logic            ram_we;
  logic [IdxW-1:0] ram_waddr;
  entry_t          ram_wdata;
  logic            ram_re;
  logic [IdxW-1:0] ram_raddr;
  entry_t          ram_rdata;

  // entry update
  logic signed [RemainW:0]   diff;
  logic signed [RemainW-1:0] rem_sat;
  logic signed [RemainW-1:0] rem_new;
  logic                      fire;
  logic                      keep;
  logic                      last_entry;
  logic                      out_free;
  logic                      full;

  // push into output register
  logic              push;
  logic [IdW-1:0]    push_id;
  logic [DeltaW-1:0] push_delta;
  logic [1:0]        push_status;
  logic              push_last;

  stt_ram #(
    .Width ($bits(entry_t)),
    .Depth (MaxTimers)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign full       = (count_q == CntW'(MaxTimers));
  assign last_entry = ((rd_q + CntW'(1)) == count_q);

  // subtract delta with saturation, then reload or drop
  always_comb begin
    diff = {ram_rdata.remain[RemainW-1], ram_rdata.remain}
         - $signed({{(RemainW + 1 - DeltaW){1'b0}}, delta_q});
    if (diff[RemainW] && !diff[RemainW-1]) begin
      rem_sat = {1'b1, {(RemainW - 1){1'b0}}};
    end else begin
      rem_sat = diff[RemainW-1:0];
    end
    fire    = rem_sat[RemainW-1];
    keep    = !fire || ram_rdata.periodic;
    rem_new = fire ? rem_sat + $signed({{(RemainW - PeriodW){1'b0}}, ram_rdata.period})
                   : rem_sat;
  end

  // table read and write
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = '0;
    ram_we    = 1'b0;
    ram_waddr = wr_q[IdxW-1:0];
    ram_wdata = ram_rdata;
    ram_wdata.remain = rem_new;
    if (cmd_i.accept && (in_mode_i == ModeTick)) begin
      ram_re = 1'b1;
    end else if (cmd_i.advance && !last_entry) begin
      ram_re    = 1'b1;
      ram_raddr = rd_d[IdxW-1:0];
    end
    if (cmd_i.advance) begin
      ram_we = keep;
    end else if (cmd_i.reg_commit) begin
      ram_we    = !full;
      ram_waddr = count_q[IdxW-1:0];
      ram_wdata = '{id:       id_q,
                    periodic: periodic_q,
                    period:   period_q,
                    remain:   $signed({{(RemainW - PeriodW){1'b0}}, period_q})};
    end
  end

  // walk counters and pending fired timer
  always_comb begin
    count_d      = count_q;
    rd_d         = rd_q + CntW'(1);
    wr_d         = wr_q;
    pend_valid_d = pend_valid_q;
    pend_id_d    = pend_id_q;
    push         = 1'b0;
    push_id      = '0;
    push_delta   = '0;
    push_status  = StNone;
    push_last    = 1'b1;
    if (cmd_i.accept) begin
      rd_d         = '0;
      wr_d         = '0;
      pend_valid_d = 1'b0;
    end else if (cmd_i.advance) begin
      if (keep) begin
        wr_d = wr_q + CntW'(1);
      end
      if (fire) begin
        pend_valid_d = 1'b1;
        pend_id_d    = ram_rdata.id;
        if (pend_valid_q) begin
          push        = 1'b1;
          push_id     = pend_id_q;
          push_delta  = delta_q;
          push_status = StFired;
          push_last   = 1'b0;
        end
      end
    end else if (cmd_i.reg_commit) begin
      push        = 1'b1;
      push_status = full ? StFull : StRegistered;
      if (!full) begin
        count_d = count_q + CntW'(1);
      end
    end else if (cmd_i.finish) begin
      push    = 1'b1;
      count_d = wr_q;
      if (pend_valid_q) begin
        push_id     = pend_id_q;
        push_delta  = delta_q;
        push_status = StFired;
      end
    end
    if (!cmd_i.accept && !cmd_i.advance) begin
      rd_d = rd_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      rd_q         <= '0;
      wr_q         <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      count_q      <= count_d;
      rd_q         <= rd_d;
      wr_q         <= wr_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= push || (out_valid_q && !out_ready_i);
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pend_id_q <= pend_id_d;
    if (cmd_i.accept) begin
      delta_q    <= in_data_i[15:0];
      id_q       <= in_data_i[23:16];
      periodic_q <= in_data_i[24];
      period_q   <= in_data_i[48:25];
    end
    if (push) begin
      out_id_q     <= push_id;
      out_delta_q  <= push_delta;
      out_status_q <= push_status;
      out_last_q   <= push_last;
    end
  end

  // status to controller
  assign sts_o = '{in_valid:     in_valid_i,
                   in_mode:      in_mode_i,
                   empty:        (count_q == '0),
                   fire_blocked: fire && pend_valid_q && !out_free,
                   last_entry:   last_entry,
                   out_free:     out_free};

  assign out_valid_o  = out_valid_q;
  assign out_data_o   = {out_delta_q, out_id_q};
  assign out_status_o = out_status_q;
  assign out_last_o   = out_last_q;

endmodule

FILE: hw/rtl/software_timer_table.sv
// register request: committed in state StReg, result held in the output register
// tick request: walks the live entries one at a time through the single read port of
// the table ram, pausing while a fired result cannot be queued, then a final result
// throughput: one request at a time, next request taken once the last result is queued
// reset: asynchronous active low, clears the live count and control state; table
// contents are undefined until written and need no clearing pass
module software_timer_table
  import stt_pkg::*;
#(
  parameter int unsigned MAX_TIMERS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // delta_ms[15:0], event_id[23:16], periodic[24],
                                     // period_ms[48:25], zero fill
  input  logic        s_axis_tuser,  // mode[0]
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // fired_id[7:0], fired_delta[23:8]
  output logic [1:0]  m_axis_tuser,  // status[1:0]
  output logic        m_axis_tlast   // last
);

  cmd_t cmd;
  sts_t sts;

  // sequencer
  stt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_ready_o (s_axis_tready)
  );

  // table, walk counters and output register
  stt_datapath #(
    .MaxTimers (MAX_TIMERS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_data_i    (s_axis_tdata),
    .in_mode_i    (s_axis_tuser),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata),
    .out_status_o (m_axis_tuser),
    .out_last_o   (m_axis_tlast),
    .cmd_i        (cmd),
    .sts_o        (sts)
  );

endmodule

FILE: dv/software_timer_table_tb.sv
module software_timer_table_tb
  import stt_pkg::*;
();

  localparam int unsigned MaxTimers  = 16;
  localparam int          RemainMin  = -33554432;
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned TailCycles = MaxTimers + 8;
  localparam int unsigned MaxReports = 10;

  // one request as the sender sees it
  typedef struct packed {
    logic               mode;
    logic [DeltaW-1:0]  delta;
    logic [IdW-1:0]     id;
    logic               periodic;
    logic [PeriodW-1:0] period;
  } timer_req_t;

  // one result as the receiver sees it
  typedef struct packed {
    logic [1:0]        status;
    logic [IdW-1:0]    id;
    logic [DeltaW-1:0] delta;
    logic              last;
  } timer_res_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata;   // delta_ms, event_id, periodic, period_ms, zero fill
  logic        s_axis_tuser;   // mode
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // fired_id, fired_delta
  logic [1:0]  m_axis_tuser;   // status
  logic        m_axis_tlast;

  // shadow copy of the timer table
  entry_t      shadow_table [MaxTimers];
  int unsigned shadow_live;
  timer_res_t  pending_results [$];

  int unsigned error_count;
  int unsigned report_count;
  int unsigned hold_cycles;
  int unsigned stall_cycles;
  int unsigned cycle_count;
  bit          calm;

  software_timer_table dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // clock, period 2
  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // expected results of one request, updates the shadow table
  function automatic void predict_timer_results(timer_req_t req);
    int          r;
    int unsigned wr;
    int unsigned fired;
    bit          keep;
    entry_t      e;
    timer_res_t  res;
    res = '{status: StRegistered, id: '0, delta: '0, last: 1'b1};
    if (req.mode == ModeRegister) begin
      if (shadow_live >= MaxTimers) begin
        res.status = StFull;
      end else begin
        e.id       = req.id;
        e.periodic = req.periodic;
        e.period   = req.period;
        e.remain   = {2'b00, req.period};
        shadow_table[shadow_live] = e;
        shadow_live++;
      end
      pending_results.push_back(res);
    end else begin
      wr    = 0;
      fired = 0;
      for (int unsigned rd = 0; rd < shadow_live; rd++) begin
        e    = shadow_table[rd];
        keep = 1'b1;
        r    = {{(32-RemainW){e.remain[RemainW-1]}}, e.remain};
        r    = r - int'(req.delta);
        if (r < RemainMin) r = RemainMin;
        if (r < 0) begin
          pending_results.push_back('{status: StFired, id: e.id, delta: req.delta,
                                      last: 1'b0});
          fired++;
          if (e.periodic) begin
            r = r + int'(e.period);
          end else begin
            keep = 1'b0;
          end
        end
        if (keep) begin
          e.remain = r[RemainW-1:0];
          shadow_table[wr] = e;
          wr++;
        end
      end
      shadow_live = wr;
      if (fired == 0) begin
        res.status = StNone;
        pending_results.push_back(res);
      end else begin
        res      = pending_results.pop_back();
        res.last = 1'b1;
        pending_results.push_back(res);
      end
    end
  endfunction

  function automatic timer_req_t tick_req(int unsigned delta);
    timer_req_t req;
    req.mode     = ModeTick;
    req.delta    = DeltaW'(delta);
    req.id       = IdW'($urandom_range(0, 255));
    req.periodic = 1'($urandom_range(0, 1));
    req.period   = PeriodW'($urandom());
    return req;
  endfunction

  function automatic timer_req_t reg_req(int unsigned id, bit periodic, int unsigned period);
    timer_req_t req;
    req.mode     = ModeRegister;
    req.delta    = DeltaW'($urandom_range(0, 65535));
    req.id       = IdW'(id);
    req.periodic = periodic;
    req.period   = PeriodW'(period);
    return req;
  endfunction

  function automatic void note_mismatch(string what, timer_res_t want, timer_res_t got);
    error_count++;
    if (report_count < MaxReports) begin
      report_count++;
      $display("%s: expected st %0d id %0d dl %0d last %0d, got st %0d id %0d dl %0d last %0d",
               what, want.status, want.id, want.delta, want.last,
               got.status, got.id, got.delta, got.last);
    end
  endfunction

  // offer one request, with a random gap in front, until it is taken
  task automatic send_request(timer_req_t req);
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = req.mode;
    s_axis_tdata  = {7'd0, req.period, req.periodic, req.id, req.delta};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_timer_results(req);
  endtask

  // stop sending until every pending result has come back
  task automatic wait_for_results();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // receiver ready with long holds and short random stalls
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      m_axis_tready = 1'b0;
      hold_cycles--;
    end else if (stall_cycles > 0) begin
      m_axis_tready = 1'b0;
      stall_cycles--;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      m_axis_tready = 1'b0;
      stall_cycles  = $urandom_range(0, 9);
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  // compare each result with the oldest pending one
  always @(posedge clk_i) begin : check_results
    timer_res_t got;
    timer_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[23:8], m_axis_tlast};
      if (pending_results.size() == 0) begin
        want = '0;
        note_mismatch("unexpected result", want, got);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.id !== want.id ||
            got.delta !== want.delta || got.last !== want.last) begin
          note_mismatch("wrong result", want, got);
        end
      end
    end
  end

  // run limit
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("software_timer_table: mismatch");
    $finish;
  end

  // tick on an empty table
  task automatic test_empty_tick();
    send_request(tick_req(16'hFFFF));
  endtask

  // fill the table, overflow it, then fire every entry in one tick
  task automatic test_full_table();
    int unsigned id;
    for (int unsigned i = 0; i < MaxTimers; i++) begin
      id = (i == 0) ? 0 : (i == MaxTimers - 1) ? 255 : $urandom_range(1, 254);
      send_request(reg_req(id, 1'b0, (i % 2 == 0) ? 0 : $urandom_range(1, 65534)));
    end
    // zero remaining does not fire
    send_request(tick_req(0));
    send_request(reg_req($urandom_range(0, 255), 1'b1, 24'hFFFFFF));
    send_request(tick_req(16'hFFFF));
  endtask

  // one-shots fire out of the middle, later ones move up in order
  task automatic test_compaction();
    send_request(reg_req($urandom_range(0, 255), 1'b0, 5));
    send_request(reg_req($urandom_range(0, 255), 1'b0, 100));
    send_request(reg_req($urandom_range(0, 255), 1'b0, 5));
    send_request(reg_req($urandom_range(0, 255), 1'b0, 100));
    send_request(reg_req($urandom_range(0, 255), 1'b0, 5));
    send_request(tick_req(6));
    send_request(tick_req(200));
  endtask

  // zero period periodic stays negative and fires on every tick
  task automatic test_short_period();
    send_request(reg_req($urandom_range(0, 255), 1'b1, 0));
    send_request(tick_req(1));
    send_request(tick_req(0));
    send_request(reg_req($urandom_range(0, 255), 1'b1, 24'hFFFFFF));
  endtask

  // mixed registers and ticks with random content
  task automatic test_random(int unsigned count);
    int unsigned period;
    repeat (count) begin
      if ($urandom_range(0, (shadow_live < MaxTimers - 2) ? 1 : 3) == 0) begin
        period = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 24'hFFFFFF)
                                              : $urandom_range(0, 300);
        send_request(reg_req($urandom_range(0, 255), $urandom_range(0, 31) == 0, period));
      end else begin
        send_request(tick_req(($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                                          : $urandom_range(0, 80)));
      end
    end
  endtask

  // receiver holds off while requests keep coming, then the sender drains
  task automatic test_backpressure();
    @(posedge clk_i);
    hold_cycles = 300;
    repeat (6) send_request(reg_req($urandom_range(0, 255), 1'b0, $urandom_range(0, 120)));
    repeat (8) send_request(tick_req($urandom_range(10, 40)));
    wait_for_results();
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = ModeTick;
    m_axis_tready = 1'b0;
    shadow_live   = 0;
    error_count   = 0;
    report_count  = 0;
    hold_cycles   = 0;
    stall_cycles  = 0;
    calm          = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_tick();
    test_full_table();
    test_compaction();
    test_short_period();
    test_random(130);
    test_backpressure();
    test_random(115);
    calm = 1'b1;
    test_random(60);

    wait_for_results();
    repeat (TailCycles) @(posedge clk_i);
    if (pending_results.size() != 0) error_count++;
    if (error_count == 0) begin
      $display("software_timer_table: match");
    end else begin
      $display("software_timer_table: mismatch");
    end
    $finish;
  end

endmodule
